// ----- hw/rtl/etp_pkg.sv -----
package etp_pkg;

    localparam int MAX_FUNCS_DEF   = 256;
    localparam int STACK_DEPTH_DEF = 64;

    localparam int ID_W    = 8;
    localparam int TS_W    = 32;
    localparam int TOT_W   = 32;
    localparam int NUM_W   = 9;
    localparam int MARK_W  = 33;
    localparam int ID_SPAN = 256;

    localparam logic [NUM_W-1:0] NUM_FUNCS_RST = 9'd256;

    typedef enum logic {
        OP_START = 1'b0,
        OP_END   = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_MISMATCH  = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_ID_RANGE  = 3'd4,
        ST_TIME_BACK = 3'd5
    } t_status;

endpackage

// ----- hw/rtl/etp_ram.sv -----
module etp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/exclusive_time_profiler.sv -----
// Exclusive-time profiler: takes start/end trace requests and keeps per-function
// exclusive run time. One request is accepted per clock; each result passes from the
// input register into the result register, and a stalled result register can hold
// the request in the input register. The per-function totals live in a memory
// with a registered read, updated by one read-modify-write per request with
// write-to-read bypass, so consecutive requests on the same id keep full rate.
// Only a stalled result register holds the pipe. Totals are cleared at reset
// through per-entry valid bits, so no clearing pass is needed. The id limit
// register is written over its own valid/ready channel, which is always ready.
module exclusive_time_profiler #(
    parameter int MAX_FUNCS   = etp_pkg::MAX_FUNCS_DEF,
    parameter int STACK_DEPTH = etp_pkg::STACK_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_op,
    input  logic [etp_pkg::ID_W-1:0]   i_func_id,
    input  logic [etp_pkg::TS_W-1:0]   i_timestamp,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_update_valid,
    output logic [etp_pkg::ID_W-1:0]   o_updated_id,
    output logic [etp_pkg::TOT_W-1:0]  o_total,
    output logic [2:0]                 o_status,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [etp_pkg::NUM_W-1:0]  i_cfg_data
);

    localparam int TOT_DEPTH = (MAX_FUNCS < etp_pkg::ID_SPAN) ? MAX_FUNCS : etp_pkg::ID_SPAN;
    localparam int TAW       = $clog2(TOT_DEPTH);
    localparam int SAW       = $clog2(STACK_DEPTH);
    localparam int DW        = $clog2(STACK_DEPTH + 1);

    // input stage
    logic                        r_pv;
    etp_pkg::t_op                r_op;
    logic [etp_pkg::ID_W-1:0]    r_id;
    logic [etp_pkg::TS_W-1:0]    r_ts;

    // architectural state
    logic [etp_pkg::NUM_W-1:0]   r_num;
    logic [DW-1:0]               r_depth;
    logic [etp_pkg::ID_W-1:0]    r_top;
    logic [etp_pkg::MARK_W-1:0]  r_mark;
    logic [TOT_DEPTH-1:0]        r_tvalid_bits;

    // read side registers
    logic                        r_tvld;
    logic                        r_thit;
    logic [etp_pkg::TOT_W-1:0]   r_twd;
    logic                        r_shit;
    logic [etp_pkg::ID_W-1:0]    r_swd;

    // result stage
    logic                        r_ov;
    logic                        r_oupd;
    logic [etp_pkg::ID_W-1:0]    r_oid;
    logic [etp_pkg::TOT_W-1:0]   r_otot;
    etp_pkg::t_status            r_ostat;

    logic                        in_acc;
    logic                        proc_go;
    logic                        hold;

    logic [etp_pkg::ID_W-1:0]    below;
    logic [etp_pkg::TOT_W-1:0]   told;
    logic                        id_bad;
    logic                        ts_back;
    etp_pkg::t_status            status;
    logic                        ok;
    logic                        credit_en;
    logic [etp_pkg::ID_W-1:0]    cid;
    logic [etp_pkg::MARK_W-1:0]  delta;
    logic [etp_pkg::MARK_W:0]    sum;
    logic [etp_pkg::TOT_W-1:0]   new_tot;

    logic [DW-1:0]               n_depth;
    logic [etp_pkg::ID_W-1:0]    n_top;
    logic [etp_pkg::MARK_W-1:0]  n_mark;

    logic                        s_we;
    logic [SAW-1:0]              s_waddr;
    logic [SAW-1:0]              s_raddr;
    logic [etp_pkg::ID_W-1:0]    s_rdata;

    logic                        t_we;
    logic [TAW-1:0]              t_waddr;
    logic [TAW-1:0]              t_raddr;
    logic [etp_pkg::TOT_W-1:0]   t_rdata;

    assign o_cfg_ready = 1'b1;

    assign proc_go = r_pv && (!r_ov || !i_stall);
    assign hold    = r_pv && !proc_go;
    assign o_stall = hold;
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        below   = r_shit ? r_swd : s_rdata;
        told    = r_thit ? r_twd : (r_tvld ? t_rdata : '0);
        id_bad  = ({1'b0, r_id} >= r_num) || (32'(r_id) >= 32'(MAX_FUNCS));
        ts_back = ({1'b0, r_ts} < r_mark);

        if (id_bad) begin
            status = etp_pkg::ST_ID_RANGE;
        end else if (r_op == etp_pkg::OP_END) begin
            if (r_depth == '0) begin
                status = etp_pkg::ST_EMPTY;
            end else if (r_top != r_id) begin
                status = etp_pkg::ST_MISMATCH;
            end else if (ts_back) begin
                status = etp_pkg::ST_TIME_BACK;
            end else begin
                status = etp_pkg::ST_OK;
            end
        end else begin
            if (r_depth == DW'(STACK_DEPTH)) begin
                status = etp_pkg::ST_OVERFLOW;
            end else if (ts_back) begin
                status = etp_pkg::ST_TIME_BACK;
            end else begin
                status = etp_pkg::ST_OK;
            end
        end

        ok        = (status == etp_pkg::ST_OK);
        credit_en = ok && ((r_op == etp_pkg::OP_END) || (r_depth != '0));
        cid       = (r_op == etp_pkg::OP_START) ? r_top : r_id;

        if (r_op == etp_pkg::OP_START) begin
            delta = {1'b0, r_ts - r_mark[etp_pkg::TS_W-1:0]};
        end else begin
            delta = {1'b0, r_ts} - r_mark + etp_pkg::MARK_W'(1);
        end
        sum     = {2'b0, told} + {1'b0, delta};
        new_tot = (sum[etp_pkg::MARK_W:etp_pkg::TOT_W] != '0) ? '1 : sum[etp_pkg::TOT_W-1:0];

        n_depth = r_depth;
        n_top   = r_top;
        n_mark  = r_mark;
        if (proc_go && ok) begin
            if (r_op == etp_pkg::OP_START) begin
                n_depth = r_depth + DW'(1);
                n_top   = r_id;
                n_mark  = {1'b0, r_ts};
            end else begin
                n_depth = r_depth - DW'(1);
                n_top   = below;
                n_mark  = {1'b0, r_ts} + etp_pkg::MARK_W'(1);
            end
        end

        s_we    = proc_go && ok && (r_op == etp_pkg::OP_START) && (r_depth != '0);
        s_waddr = SAW'(r_depth - DW'(1));
        s_raddr = SAW'(n_depth - DW'(2));

        t_we    = proc_go && credit_en;
        t_waddr = cid[TAW-1:0];
        if (hold) begin
            t_raddr = (r_op == etp_pkg::OP_START) ? r_top[TAW-1:0] : r_id[TAW-1:0];
        end else begin
            t_raddr = (etp_pkg::t_op'(i_op) == etp_pkg::OP_START) ?
                      n_top[TAW-1:0] : i_func_id[TAW-1:0];
        end
    end

    etp_ram #(
        .WIDTH (etp_pkg::ID_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (r_top),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    etp_ram #(
        .WIDTH (etp_pkg::TOT_W),
        .DEPTH (TOT_DEPTH)
    ) u_totals (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (new_tot),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv          <= 1'b0;
            r_ov          <= 1'b0;
            r_num         <= etp_pkg::NUM_FUNCS_RST;
            r_depth       <= '0;
            r_top         <= '0;
            r_mark        <= '0;
            r_tvalid_bits <= '0;
            r_tvld        <= 1'b0;
            r_thit        <= 1'b0;
            r_shit        <= 1'b0;
        end else begin
            if (in_acc) begin
                r_pv <= 1'b1;
            end else if (proc_go) begin
                r_pv <= 1'b0;
            end

            if (proc_go) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end

            if (i_cfg_valid) begin
                r_num <= i_cfg_data;
            end

            r_depth <= n_depth;
            r_top   <= n_top;
            r_mark  <= n_mark;

            if (t_we) begin
                r_tvalid_bits[t_waddr] <= 1'b1;
            end
            r_tvld <= r_tvalid_bits[t_raddr];
            r_thit <= t_we && (t_waddr == t_raddr);
            r_shit <= s_we && (s_waddr == s_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_twd <= new_tot;
        r_swd <= r_top;
        if (in_acc) begin
            r_op <= etp_pkg::t_op'(i_op);
            r_id <= i_func_id;
            r_ts <= i_timestamp;
        end
        if (proc_go) begin
            r_oupd  <= credit_en;
            r_oid   <= credit_en ? cid : '0;
            r_otot  <= credit_en ? new_tot : '0;
            r_ostat <= status;
        end
    end

    assign o_valid        = r_ov;
    assign o_update_valid = r_oupd;
    assign o_updated_id   = r_oid;
    assign o_total        = r_otot;
    assign o_status       = r_ostat;

endmodule
